// ----- hdl/pslqr_pkg.sv -----
// ============================================================================
// pslqr_pkg
// Shared types, constants and tables of the pendulum swing-up/LQR controller.
// ============================================================================
package pslqr_pkg;

   localparam int COS_TABLE_DEPTH = 256;
   localparam int IDX_W           = $clog2(COS_TABLE_DEPTH);

   localparam int PI_Q12     = 12868;
   localparam int TWO_PI_Q12 = 25736;
   localparam int HALF_Q12   = 2048;
   localparam int BAND_Q12   = 6144;
   localparam int E_POLE_Q16 = 20039;
   localparam longint PI_Q28  = 64'sd843314857;
   localparam longint ONE_Q28 = 64'sd268435456;
   localparam int ONE_Q14    = 16384;
   localparam int FORCE_MIN  = -524288;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 20;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 42;
   localparam int EN_W    = 14;

   localparam int RECIP_SHIFT = 32;
   localparam longint RECIP_M =
      ((64'sd1 <<< RECIP_SHIFT) + TWO_PI_Q12 - 1) / TWO_PI_Q12;

   localparam int SWING_SHIFT = 26;
   localparam int LQR_SHIFT   = 12;

   localparam logic signed [19:0] GAIN_POSITION_RESET   = 20'(-8095);
   localparam logic signed [19:0] GAIN_VELOCITY_RESET   = 20'(-19264);
   localparam logic signed [19:0] GAIN_ANGLE_RESET      = 20'(221028);
   localparam logic signed [19:0] GAIN_ANGLE_RATE_RESET = 20'(22030);
   localparam logic [15:0] SWING_GAIN_RESET   = 16'(640);
   localparam logic [18:0] FORCE_LIMIT_RESET  = 19'(25600);
   localparam logic [12:0] CAPTURE_BAND_RESET = 13'(614);
   localparam logic [12:0] SWING_OFFSET_RESET = 13'(1229);

   typedef struct packed {
      logic signed [15:0] cart_position;
      logic signed [15:0] cart_velocity;
      logic signed [15:0] pole_angle;
      logic signed [15:0] pole_rate;
   } req_type;

   typedef struct packed {
      logic signed [19:0] drive_force;
      logic               balancing;
      logic signed [15:0] cart_setpoint;
   } rsp_type;

   typedef struct packed {
      logic signed [19:0] gain_position;
      logic signed [19:0] gain_velocity;
      logic signed [19:0] gain_angle;
      logic signed [19:0] gain_angle_rate;
      logic [15:0]        swing_gain;
      logic [18:0]        force_limit;
      logic [12:0]        capture_band;
      logic [12:0]        swing_offset;
   } cfg_type;

   typedef logic [EN_W-1:0] en_rom_type [COS_TABLE_DEPTH];

   function automatic longint cos_entry(input longint i);
      longint j2;
      longint r;
      longint x;
      longint x2;
      longint t;
      longint c;
      logic   neg;
      j2  = 2 * i;
      neg = 1'b0;
      if (2 * j2 <= COS_TABLE_DEPTH) begin
         r = j2;
      end else if (2 * j2 < 3 * COS_TABLE_DEPTH) begin
         r   = j2 - COS_TABLE_DEPTH;
         neg = 1'b1;
      end else begin
         r = j2 - 2 * COS_TABLE_DEPTH;
      end
      x  = r * PI_Q28 / COS_TABLE_DEPTH;
      x2 = (x * x) >>> 28;
      t  = ONE_Q28 - x2 / 90;
      t  = ONE_Q28 - ((x2 * t) >>> 28) / 56;
      t  = ONE_Q28 - ((x2 * t) >>> 28) / 30;
      t  = ONE_Q28 - ((x2 * t) >>> 28) / 12;
      c  = ONE_Q28 - ((x2 * t) >>> 28) / 2;
      if (c < 0) begin
         c = 0;
      end
      c = (c + 8192) >>> 14;
      return neg ? -c : c;
   endfunction

   // Pole energy term E * (1 - cos angle) in Q14 for the swing-up product.
   function automatic en_rom_type en_rom_build();
      en_rom_type rom;
      longint     onec;
      for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
         onec   = longint'(ONE_Q14) - cos_entry(longint'(i));
         rom[i] = EN_W'((longint'(E_POLE_Q16) * onec + 32768) >>> 16);
      end
      return rom;
   endfunction

   localparam en_rom_type EN_ROM = en_rom_build();

   function automatic logic signed [PROD_W-1:0] round_shr(
      input logic signed [PROD_W-1:0] v,
      input int                       s
   );
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] half;
      logic [PROD_W-1:0] r;
      mag  = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      half = PROD_W'(1) << (s - 1);
      r    = (mag + half) >> s;
      return v[PROD_W-1] ? -$signed(r) : $signed(r);
   endfunction

endpackage

// ----- hdl/pendulum_swing_up_lqr_controller_core.sv -----
// ============================================================================
// pendulum_swing_up_lqr_controller_core
// Swing-up and LQR balance controller for a cart and pole, one force per tick.
// ============================================================================
// Each transfer on the req_ channel carries one measurement of cart position,
// cart velocity, pole angle and pole rate; each transfer on the rsp_ channel
// carries the commanded force, the balance flag and the cart setpoint.
// A transfer happens when valid is high and stall is low.
// All products go through one shared 32 x 20 multiplier under a small
// sequencer, so an item in swing-up mode steps through the index search, the
// energy and gain products (or, outside the swing band, skips them), and an
// item in balance mode through four gain products and the sum. req_stall is
// high while an item is in work. The result sits in an output register; the
// next item is taken while it waits, and the sequencer holds its last step
// while the receiver stalls with an earlier result still pending.
// Reset clears the mode to swing-up with reference angle zero, clears the
// stored setpoint and loads the default gains and limits.
// Registers are written through the csr_ port at byte address 4 * index.
// ============================================================================
module pendulum_swing_up_lqr_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pslqr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pslqr_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CALC,
      S_IDX,
      S_FIX,
      S_EP,
      S_PG,
      S_SRND,
      S_L0,
      S_L1,
      S_L2,
      S_L3,
      S_L4,
      S_L5,
      S_DONE
   } state_type;

   pslqr_pkg::cfg_type cfg;

   state_type                              state_ff;
   pslqr_pkg::req_type                     in_ff;
   logic                                   balance_mode_ff;
   logic                                   upper_ref_ff;
   logic signed [15:0]                     last_setpoint_ff;
   logic signed [16:0]                     err_ff;
   logic [pslqr_pkg::IDX_W-1:0]            q_ff;
   logic [pslqr_pkg::EN_W-1:0]             en_ff;
   logic signed [pslqr_pkg::ACC_W-1:0]     acc_ff;
   logic signed [31:0]                     u_ff;
   logic                                   rsp_valid_ff;
   pslqr_pkg::rsp_type                     rsp_data_ff;

   logic signed [pslqr_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [pslqr_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [pslqr_pkg::PROD_W-1:0]   prod_ff;

   logic signed [15:0]                     ang;
   logic signed [15:0]                     pos;
   logic signed [15:0]                     offset_s;
   logic signed [15:0]                     sp;
   logic signed [16:0]                     err;
   logic                                   in_band;
   logic signed [17:0]                     hi_thr;
   logic                                   capture_lo;
   logic                                   capture_hi;
   logic signed [31:0]                     idx_num;
   logic [pslqr_pkg::IDX_W-1:0]            idx;
   logic signed [16:0]                     ang_err;
   logic signed [31:0]                     lim_s;
   logic signed [31:0]                     u_c;
   logic                                   out_free;

   pslqr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pslqr_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign ang      = in_ff.pole_angle;
   assign pos      = in_ff.cart_position;
   assign offset_s = $signed({3'b0, cfg.swing_offset});

   always_comb begin
      if ((32'(ang) < pslqr_pkg::PI_Q12 + pslqr_pkg::HALF_Q12) && in_ff.pole_rate[15]) begin
         sp = offset_s;
      end else if ((32'(ang) >= pslqr_pkg::PI_Q12 - pslqr_pkg::HALF_Q12)
                   && !in_ff.pole_rate[15]) begin
         sp = -offset_s;
      end else begin
         sp = pos;
      end
   end

   assign err        = 17'(sp) - 17'(pos);
   assign in_band    = (32'(ang) >= pslqr_pkg::PI_Q12 - pslqr_pkg::BAND_Q12)
                       && (32'(ang) < pslqr_pkg::PI_Q12 + pslqr_pkg::BAND_Q12);
   assign hi_thr     = 18'(pslqr_pkg::TWO_PI_Q12) - $signed({5'b0, cfg.capture_band});
   assign capture_lo = 18'(ang) < $signed({5'b0, cfg.capture_band});
   assign capture_hi = 18'(ang) > hi_thr;
   assign idx_num    = 32'(ang) * 32'(pslqr_pkg::COS_TABLE_DEPTH)
                       + 32'(pslqr_pkg::TWO_PI_Q12 / 2);
   assign idx        = (prod_ff > pslqr_pkg::PROD_W'(idx_num)) ? q_ff - 1'b1 : q_ff;
   assign ang_err    = 17'(ang) - (upper_ref_ff ? 17'(pslqr_pkg::TWO_PI_Q12) : 17'sd0);

   assign lim_s      = $signed({13'b0, cfg.force_limit});
   always_comb begin
      u_c = (u_ff > lim_s) ? lim_s : u_ff;
      if (u_c < pslqr_pkg::FORCE_MIN) begin
         u_c = pslqr_pkg::FORCE_MIN;
      end
   end
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_CALC: begin
            mul_a = idx_num;
            mul_b = pslqr_pkg::MUL_B_W'(pslqr_pkg::RECIP_M);
         end
         S_IDX: begin
            mul_a = pslqr_pkg::MUL_A_W'(prod_ff[pslqr_pkg::RECIP_SHIFT +: pslqr_pkg::IDX_W]);
            mul_b = pslqr_pkg::MUL_B_W'(pslqr_pkg::TWO_PI_Q12);
         end
         S_EP: begin
            mul_a = pslqr_pkg::MUL_A_W'(err_ff);
            mul_b = $signed({{(pslqr_pkg::MUL_B_W - pslqr_pkg::EN_W){1'b0}}, en_ff});
         end
         S_PG: begin
            mul_a = prod_ff[pslqr_pkg::MUL_A_W-1:0];
            mul_b = $signed({4'b0, cfg.swing_gain});
         end
         S_L0: begin
            mul_a = pslqr_pkg::MUL_A_W'(pos);
            mul_b = cfg.gain_position;
         end
         S_L1: begin
            mul_a = pslqr_pkg::MUL_A_W'(in_ff.cart_velocity) <<< 2;
            mul_b = cfg.gain_velocity;
         end
         S_L2: begin
            mul_a = pslqr_pkg::MUL_A_W'(ang_err);
            mul_b = cfg.gain_angle;
         end
         S_L3: begin
            mul_a = pslqr_pkg::MUL_A_W'(in_ff.pole_rate) <<< 2;
            mul_b = cfg.gain_angle_rate;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         balance_mode_ff  <= 1'b0;
         upper_ref_ff     <= 1'b0;
         last_setpoint_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  in_ff    <= req_data;
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               err_ff <= err;
               if (!balance_mode_ff) begin
                  last_setpoint_ff <= sp;
                  if (capture_lo || capture_hi) begin
                     balance_mode_ff <= 1'b1;
                     upper_ref_ff    <= capture_hi;
                  end
               end
               if (balance_mode_ff || capture_lo || capture_hi) begin
                  state_ff <= S_L0;
               end else if (in_band) begin
                  state_ff <= S_IDX;
               end else begin
                  u_ff     <= '0;
                  state_ff <= S_DONE;
               end
            end
            S_IDX: begin
               q_ff     <= prod_ff[pslqr_pkg::RECIP_SHIFT +: pslqr_pkg::IDX_W];
               state_ff <= S_FIX;
            end
            S_FIX: begin
               en_ff    <= pslqr_pkg::EN_ROM[idx];
               state_ff <= S_EP;
            end
            S_EP: begin
               state_ff <= S_PG;
            end
            S_PG: begin
               state_ff <= S_SRND;
            end
            S_SRND: begin
               u_ff     <= 32'(pslqr_pkg::round_shr(prod_ff, pslqr_pkg::SWING_SHIFT));
               state_ff <= S_DONE;
            end
            S_L0: begin
               state_ff <= S_L1;
            end
            S_L1: begin
               acc_ff   <= $signed(prod_ff[pslqr_pkg::ACC_W-1:0]);
               state_ff <= S_L2;
            end
            S_L2: begin
               acc_ff   <= acc_ff + $signed(prod_ff[pslqr_pkg::ACC_W-1:0]);
               state_ff <= S_L3;
            end
            S_L3: begin
               acc_ff   <= acc_ff + $signed(prod_ff[pslqr_pkg::ACC_W-1:0]);
               state_ff <= S_L4;
            end
            S_L4: begin
               acc_ff   <= acc_ff + $signed(prod_ff[pslqr_pkg::ACC_W-1:0]);
               state_ff <= S_L5;
            end
            S_L5: begin
               u_ff     <= -32'(pslqr_pkg::round_shr(pslqr_pkg::PROD_W'(acc_ff),
                                                     pslqr_pkg::LQR_SHIFT));
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_data_ff.drive_force   <= u_c[19:0];
                  rsp_data_ff.balancing     <= balance_mode_ff;
                  rsp_data_ff.cart_setpoint <= last_setpoint_ff;
                  rsp_valid_ff              <= 1'b1;
                  state_ff                  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/pslqr_mul.sv -----
// ============================================================================
// pslqr_mul
// Shared signed multiplier with a registered product.
// ============================================================================
module pslqr_mul (
   input  logic                                  clock,
   input  logic signed [pslqr_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [pslqr_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [pslqr_pkg::PROD_W-1:0]  prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= pslqr_pkg::PROD_W'(mul_a) * pslqr_pkg::PROD_W'(mul_b);
   end

endmodule

// ----- hdl/pslqr_csr.sv -----
// ============================================================================
// pslqr_csr
// Configuration registers behind an APB-style port.
// ============================================================================
module pslqr_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output pslqr_pkg::cfg_type cfg
);

   typedef enum logic [2:0] {
      REG_GAIN_POSITION,
      REG_GAIN_VELOCITY,
      REG_GAIN_ANGLE,
      REG_GAIN_ANGLE_RATE,
      REG_SWING_GAIN,
      REG_FORCE_LIMIT,
      REG_CAPTURE_BAND,
      REG_SWING_OFFSET
   } reg_index_type;

   pslqr_pkg::cfg_type cfg_ff;
   reg_index_type      index;
   logic               write_en;

   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_position   <= pslqr_pkg::GAIN_POSITION_RESET;
         cfg_ff.gain_velocity   <= pslqr_pkg::GAIN_VELOCITY_RESET;
         cfg_ff.gain_angle      <= pslqr_pkg::GAIN_ANGLE_RESET;
         cfg_ff.gain_angle_rate <= pslqr_pkg::GAIN_ANGLE_RATE_RESET;
         cfg_ff.swing_gain      <= pslqr_pkg::SWING_GAIN_RESET;
         cfg_ff.force_limit     <= pslqr_pkg::FORCE_LIMIT_RESET;
         cfg_ff.capture_band    <= pslqr_pkg::CAPTURE_BAND_RESET;
         cfg_ff.swing_offset    <= pslqr_pkg::SWING_OFFSET_RESET;
      end else if (write_en) begin
         case (index)
            REG_GAIN_POSITION:   cfg_ff.gain_position   <= csr_pwdata[19:0];
            REG_GAIN_VELOCITY:   cfg_ff.gain_velocity   <= csr_pwdata[19:0];
            REG_GAIN_ANGLE:      cfg_ff.gain_angle      <= csr_pwdata[19:0];
            REG_GAIN_ANGLE_RATE: cfg_ff.gain_angle_rate <= csr_pwdata[19:0];
            REG_SWING_GAIN:      cfg_ff.swing_gain      <= csr_pwdata[15:0];
            REG_FORCE_LIMIT:     cfg_ff.force_limit     <= csr_pwdata[18:0];
            REG_CAPTURE_BAND:    cfg_ff.capture_band    <= csr_pwdata[12:0];
            REG_SWING_OFFSET:    cfg_ff.swing_offset    <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_GAIN_POSITION:   csr_prdata = {12'b0, cfg_ff.gain_position};
         REG_GAIN_VELOCITY:   csr_prdata = {12'b0, cfg_ff.gain_velocity};
         REG_GAIN_ANGLE:      csr_prdata = {12'b0, cfg_ff.gain_angle};
         REG_GAIN_ANGLE_RATE: csr_prdata = {12'b0, cfg_ff.gain_angle_rate};
         REG_SWING_GAIN:      csr_prdata = {16'b0, cfg_ff.swing_gain};
         REG_FORCE_LIMIT:     csr_prdata = {13'b0, cfg_ff.force_limit};
         REG_CAPTURE_BAND:    csr_prdata = {19'b0, cfg_ff.capture_band};
         REG_SWING_OFFSET:    csr_prdata = {19'b0, cfg_ff.swing_offset};
         default:             csr_prdata = 32'b0;
      endcase
   end

endmodule

// ----- tb/pendulum_swing_up_lqr_controller_core_tb.sv -----
// ============================================================================
// pendulum_swing_up_lqr_controller_core_tb
// Self-checking testbench of the pendulum swing-up and LQR balance controller.
// ============================================================================
// A short table of directed measurements runs first, with known commands for
// the ticks outside the swing band. Random swing-up phases follow under
// extreme and random register settings, with the angle kept out of the
// capture band. A single capture tick then switches the block to balance
// mode, on a randomly chosen side, and random balance phases follow. All
// other commands are checked against a bit-accurate controller predictor.
// The sender and the receiver idle at different rates from phase to phase.
// One phase holds the receiver off long enough to stall the input, and one
// pauses the sender until every pending command has arrived.
// ============================================================================
module pendulum_swing_up_lqr_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ANGLE_PI      = 12868;
   localparam int     ANGLE_2PI     = 25736;
   localparam int     SETPOINT_HALF = 2048;
   localparam int     SWING_BAND    = 6144;
   localparam longint POLE_ENERGY   = 20039;
   localparam longint PI_Q28        = 64'sd843314857;
   localparam longint ONE_Q28       = 64'sd268435456;
   localparam longint ONE_Q14       = 16384;
   localparam longint FORCE_FLOOR   = -524288;
   localparam longint FORCE_CEIL    = 524287;
   localparam int     TABLE_DEPTH   = pslqr_pkg::COS_TABLE_DEPTH;
   localparam int     DIRECTED_ROWS = 20;
   localparam int     SWING_ITEMS   = 150;
   localparam int     BALANCE_ITEMS = 215;
   localparam int     HOLD_CYCLES   = 300;

   typedef enum logic [2:0] {
      REG_GAIN_POSITION,
      REG_GAIN_VELOCITY,
      REG_GAIN_ANGLE,
      REG_GAIN_ANGLE_RATE,
      REG_SWING_GAIN,
      REG_FORCE_LIMIT,
      REG_CAPTURE_BAND,
      REG_SWING_OFFSET
   } reg_index_e;

   typedef enum int {SET_LOW, SET_HIGH, SET_RANDOM, SET_MILD} setting_e;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;

   typedef struct packed {
      logic               known;
      pslqr_pkg::req_type m;
      pslqr_pkg::rsp_type want;
   } directed_row_t;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   pslqr_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   pslqr_pkg::rsp_type rsp_data;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [4:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   pslqr_pkg::cfg_type ctrl_cfg;
   logic               balance_active;
   logic               upper_side;
   logic signed [15:0] held_setpoint;

   pslqr_pkg::rsp_type expected_commands [$];
   directed_row_t      directed_plan [DIRECTED_ROWS];
   int                 mismatch_count = 0;
   int                 src_idle_pct   = 0;
   int                 sink_stall_pct = 0;
   logic               hold_request   = 1'b0;

   pendulum_swing_up_lqr_controller_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(32'(hi - lo), 0));
   endfunction

   function automatic longint round_away(input longint v, input int s);
      longint half;
      half = longint'(1) <<< (s - 1);
      if (v < 0) begin
         return -((-v + half) >>> s);
      end
      return (v + half) >>> s;
   endfunction

   function automatic longint cos_q14(input longint i);
      longint j2;
      longint r;
      longint x;
      longint x2;
      longint t;
      logic   flip;
      j2   = 2 * i;
      flip = 1'b0;
      if (2 * j2 <= TABLE_DEPTH) begin
         r = j2;
      end else if (2 * j2 < 3 * TABLE_DEPTH) begin
         r    = j2 - TABLE_DEPTH;
         flip = 1'b1;
      end else begin
         r = j2 - 2 * TABLE_DEPTH;
      end
      x  = r * PI_Q28 / TABLE_DEPTH;
      x2 = (x * x) >>> 28;
      t  = ONE_Q28;
      for (int n = 5; n >= 1; n--) begin
         t = ONE_Q28 - ((x2 * t) >>> 28) / (2 * n * (2 * n - 1));
      end
      if (t < 0) begin
         t = 0;
      end
      t = (t + 8192) >>> 14;
      return flip ? -t : t;
   endfunction

   function automatic pslqr_pkg::rsp_type predict_command(input pslqr_pkg::req_type m);
      longint             pos;
      longint             vel;
      longint             ang;
      longint             rate;
      longint             band;
      longint             u;
      longint             sp;
      longint             idx;
      longint             energy;
      longint             ref_angle;
      longint             sum;
      pslqr_pkg::rsp_type r;
      pos  = m.cart_position;
      vel  = m.cart_velocity;
      ang  = m.pole_angle;
      rate = m.pole_rate;
      band = ctrl_cfg.capture_band;
      u    = 0;
      if (!balance_active) begin
         if (ang < ANGLE_PI + SETPOINT_HALF && rate < 0) begin
            sp = ctrl_cfg.swing_offset;
         end else if (ang >= ANGLE_PI - SETPOINT_HALF && rate >= 0) begin
            sp = -longint'(ctrl_cfg.swing_offset);
         end else begin
            sp = pos;
         end
         held_setpoint = 16'(sp);
         if (ang >= ANGLE_PI - SWING_BAND && ang < ANGLE_PI + SWING_BAND) begin
            idx    = ((ang * TABLE_DEPTH) + ANGLE_2PI / 2) / ANGLE_2PI % TABLE_DEPTH;
            energy = round_away(POLE_ENERGY * (ONE_Q14 - cos_q14(idx)), 16);
            u      = round_away(longint'(ctrl_cfg.swing_gain) * (sp - pos) * energy, 26);
         end
         if (ang < band || ang > ANGLE_2PI - band) begin
            balance_active = 1'b1;
            if (ang > ANGLE_2PI - band) begin
               upper_side = 1'b1;
            end
         end
      end
      if (balance_active) begin
         ref_angle = upper_side ? ANGLE_2PI : 0;
         sum = longint'(ctrl_cfg.gain_position) * pos
             + longint'(ctrl_cfg.gain_velocity) * vel * 4
             + longint'(ctrl_cfg.gain_angle) * (ang - ref_angle)
             + longint'(ctrl_cfg.gain_angle_rate) * rate * 4;
         u = -round_away(sum, 12);
      end
      if (u > longint'(ctrl_cfg.force_limit)) begin
         u = ctrl_cfg.force_limit;
      end
      if (u > FORCE_CEIL) begin
         u = FORCE_CEIL;
      end
      if (u < FORCE_FLOOR) begin
         u = FORCE_FLOOR;
      end
      r.drive_force   = 20'(u);
      r.balancing     = balance_active;
      r.cart_setpoint = held_setpoint;
      return r;
   endfunction

   function automatic logic signed [15:0] any_field();
      if ($urandom_range(1, 0) == 1) begin
         return 16'($urandom);
      end
      return 16'(pick(-2048, 2047));
   endfunction

   function automatic pslqr_pkg::req_type swing_measurement();
      pslqr_pkg::req_type m;
      int                 lo;
      int                 hi;
      int                 ang;
      lo = ctrl_cfg.capture_band;
      hi = ANGLE_2PI - int'(ctrl_cfg.capture_band);
      case ($urandom_range(9, 0))
         7, 8: ang = pick(lo, hi);
         9: begin
            case ($urandom_range(8, 0))
               0: ang = lo;
               1: ang = hi;
               2: ang = ANGLE_PI - SETPOINT_HALF;
               3: ang = ANGLE_PI - SETPOINT_HALF - 1;
               4: ang = ANGLE_PI + SETPOINT_HALF;
               5: ang = ANGLE_PI + SETPOINT_HALF - 1;
               6: ang = ANGLE_PI - SWING_BAND;
               7: ang = ANGLE_PI + SWING_BAND - 1;
               default: ang = ANGLE_PI + SWING_BAND;
            endcase
         end
         default: ang = pick(ANGLE_PI - SWING_BAND - 200, ANGLE_PI + SWING_BAND + 200);
      endcase
      m.cart_position = any_field();
      m.cart_velocity = 16'($urandom);
      m.pole_angle    = 16'(ang);
      case ($urandom_range(9, 0))
         0, 1: m.pole_rate = 16'(pick(-64, 63));
         2: m.pole_rate = ($urandom_range(1, 0) == 1) ? 16'sd0 : -16'sd1;
         3: m.pole_rate = ($urandom_range(1, 0) == 1) ? 16'h7fff : 16'h8000;
         default: m.pole_rate = 16'($urandom);
      endcase
      return m;
   endfunction

   function automatic pslqr_pkg::req_type balance_measurement();
      pslqr_pkg::req_type m;
      m.cart_position   = any_field();
      m.cart_velocity   = any_field();
      m.pole_rate       = any_field();
      case ($urandom_range(9, 0))
         0, 1, 2: m.pole_angle = 16'(pick(-2048, 2048));
         3, 4: m.pole_angle = 16'(ANGLE_2PI + pick(-2048, 2048));
         default: m.pole_angle = 16'($urandom);
      endcase
      return m;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t ns: %s", $realtime, what);
      end
   endtask

   task automatic set_idling(input idling_e mode);
      case (mode)
         IDLE_SENDER: begin
            src_idle_pct   = 69;
            sink_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            src_idle_pct   = 0;
            sink_stall_pct = 69;
         end
         IDLE_BOTH: begin
            src_idle_pct   = 14;
            sink_stall_pct = 14;
         end
         default: begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
         end
      endcase
   endtask

   task automatic send_measurement(input pslqr_pkg::req_type m, input logic known,
                                   input pslqr_pkg::rsp_type known_want);
      pslqr_pkg::rsp_type want;
      @(negedge clock);
      while ($urandom_range(99, 0) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (req_stall);
      want = predict_command(m);
      expected_commands.push_back(known ? known_want : want);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_commands.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic program_register(input reg_index_e idx, input int value);
      logic [31:0] mask;
      logic [31:0] got;
      case (idx)
         REG_GAIN_POSITION: begin
            mask                   = 32'hfffff;
            ctrl_cfg.gain_position = value[19:0];
         end
         REG_GAIN_VELOCITY: begin
            mask                   = 32'hfffff;
            ctrl_cfg.gain_velocity = value[19:0];
         end
         REG_GAIN_ANGLE: begin
            mask                = 32'hfffff;
            ctrl_cfg.gain_angle = value[19:0];
         end
         REG_GAIN_ANGLE_RATE: begin
            mask                     = 32'hfffff;
            ctrl_cfg.gain_angle_rate = value[19:0];
         end
         REG_SWING_GAIN: begin
            mask                = 32'hffff;
            ctrl_cfg.swing_gain = value[15:0];
         end
         REG_FORCE_LIMIT: begin
            mask                 = 32'h7ffff;
            ctrl_cfg.force_limit = value[18:0];
         end
         REG_CAPTURE_BAND: begin
            mask                  = 32'h1fff;
            ctrl_cfg.capture_band = value[12:0];
         end
         default: begin
            mask                  = 32'h1fff;
            ctrl_cfg.swing_offset = value[12:0];
         end
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(4 * idx);
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if ((got & mask) != (32'(value) & mask)) begin
         note_mismatch($sformatf("register %s read back %0h, expected %0h",
                                 idx.name(), got & mask, 32'(value) & mask));
      end
   endtask

   task automatic apply_settings(input setting_e kind);
      int gains [4];
      int swing_gain;
      int limit;
      int band;
      int offset;
      for (int g = 0; g < 4; g++) begin
         case (kind)
            SET_LOW: gains[g] = -524288;
            SET_HIGH: gains[g] = 524287;
            SET_RANDOM: gains[g] = pick(-524288, 524287);
            default: gains[g] = pick(-40000, 40000);
         endcase
      end
      case (kind)
         SET_LOW: begin
            swing_gain = 0;
            limit      = 0;
            band       = 0;
            offset     = 0;
         end
         SET_HIGH: begin
            swing_gain = 65535;
            limit      = 524287;
            band       = 4096;
            offset     = 4096;
         end
         SET_RANDOM: begin
            swing_gain = pick(0, 65535);
            limit      = pick(0, 524287);
            band       = pick(0, 4096);
            offset     = pick(0, 4096);
         end
         default: begin
            swing_gain = pick(0, 65535);
            limit      = pick(20000, 524287);
            band       = pick(0, 4096);
            offset     = pick(0, 4096);
         end
      endcase
      program_register(REG_GAIN_POSITION, gains[0]);
      program_register(REG_GAIN_VELOCITY, gains[1]);
      program_register(REG_GAIN_ANGLE, gains[2]);
      program_register(REG_GAIN_ANGLE_RATE, gains[3]);
      program_register(REG_SWING_GAIN, swing_gain);
      program_register(REG_FORCE_LIMIT, limit);
      program_register(REG_CAPTURE_BAND, band);
      program_register(REG_SWING_OFFSET, offset);
   endtask

   initial begin : receiver
      int hold_count;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
               @(negedge clock);
            end
            hold_request = 1'b0;
         end
         rsp_stall <= ($urandom_range(99, 0) < sink_stall_pct);
      end
   end

   always @(posedge clock) begin : check_commands
      pslqr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_commands.size() == 0) begin
            note_mismatch("command transfer with no command expected");
         end else begin
            want = expected_commands.pop_front();
            if (rsp_data.drive_force !== want.drive_force) begin
               note_mismatch($sformatf("drive_force expected %0d, got %0d",
                                       want.drive_force, rsp_data.drive_force));
            end
            if (rsp_data.balancing !== want.balancing) begin
               note_mismatch($sformatf("balancing expected %0d, got %0d",
                                       want.balancing, rsp_data.balancing));
            end
            if (rsp_data.cart_setpoint !== want.cart_setpoint) begin
               note_mismatch($sformatf("cart_setpoint expected %0d, got %0d",
                                       want.cart_setpoint, rsp_data.cart_setpoint));
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      pslqr_pkg::req_type m;
      int                 low_side;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      balance_active           = 1'b0;
      upper_side               = 1'b0;
      held_setpoint            = '0;
      ctrl_cfg.gain_position   = pslqr_pkg::GAIN_POSITION_RESET;
      ctrl_cfg.gain_velocity   = pslqr_pkg::GAIN_VELOCITY_RESET;
      ctrl_cfg.gain_angle      = pslqr_pkg::GAIN_ANGLE_RESET;
      ctrl_cfg.gain_angle_rate = pslqr_pkg::GAIN_ANGLE_RATE_RESET;
      ctrl_cfg.swing_gain      = pslqr_pkg::SWING_GAIN_RESET;
      ctrl_cfg.force_limit     = pslqr_pkg::FORCE_LIMIT_RESET;
      ctrl_cfg.capture_band    = pslqr_pkg::CAPTURE_BAND_RESET;
      ctrl_cfg.swing_offset    = pslqr_pkg::SWING_OFFSET_RESET;

      // Ticks outside the swing band command no force, so their results are known.
      directed_plan = '{
         '{1'b1, '{16'sd0, 16'sd0, 16'sd20000, 16'sd0}, '{20'sd0, 1'b0, -16'sd1229}},
         '{1'b1, '{16'h7fff, 16'h8000, 16'sd20000, -16'sd1},
           '{20'sd0, 1'b0, 16'h7fff}},
         '{1'b1, '{16'h8000, 16'h7fff, 16'sd1000, 16'h8000},
           '{20'sd0, 1'b0, 16'sd1229}},
         '{1'b1, '{16'h8000, 16'sd0, 16'sd6723, 16'h7fff}, '{20'sd0, 1'b0, 16'h8000}},
         '{1'b1, '{16'sd100, 16'sd0, 16'sd614, 16'sd0}, '{20'sd0, 1'b0, 16'sd100}},
         '{1'b1, '{16'sd7, 16'sd0, 16'sd25122, -16'sd5}, '{20'sd0, 1'b0, 16'sd7}},
         '{1'b0, '{16'sd0, 16'sd0, 16'sd12868, 16'sd0}, '0},
         '{1'b0, '{16'sd0, 16'sd0, 16'sd6724, 16'sd5}, '0},
         '{1'b0, '{16'sd0, 16'sd0, 16'sd19011, -16'sd5}, '0},
         '{1'b0, '{16'sd4096, 16'sd0, 16'sd14915, -16'sd1}, '0},
         '{1'b0, '{16'sd4096, 16'sd0, 16'sd14916, -16'sd1}, '0},
         '{1'b0, '{-16'sd4096, 16'sd0, 16'sd10820, 16'sd0}, '0},
         '{1'b0, '{-16'sd4096, 16'sd0, 16'sd10819, 16'sd0}, '0},
         '{1'b0, '{16'h7fff, 16'h7fff, 16'sd12868, 16'h7fff}, '0},
         '{1'b0, '{16'h8000, 16'h8000, 16'sd12868, 16'h8000}, '0},
         '{1'b0, '{16'h7fff, 16'sd0, 16'sd9000, 16'h8000}, '0},
         '{1'b0, '{16'h8000, 16'sd0, 16'sd17000, 16'h7fff}, '0},
         '{1'b0, '{16'sd1229, 16'sd0, 16'sd12868, -16'sd1}, '0},
         '{1'b0, '{-16'sd1229, 16'sd0, 16'sd12868, 16'sd0}, '0},
         '{1'b0, '{16'sd12345, -16'sd777, 16'sd8000, 16'sd100}, '0}
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_measurement(directed_plan[r].m, directed_plan[r].known, directed_plan[r].want);
      end

      for (int p = 0; p < 4; p++) begin
         wait_for_drain();
         case (p)
            0: apply_settings(SET_MILD);
            1: apply_settings(SET_HIGH);
            2: apply_settings(SET_LOW);
            default: apply_settings(SET_RANDOM);
         endcase
         set_idling(idling_e'(p));
         for (int n = 0; n < SWING_ITEMS; n++) begin
            send_measurement(swing_measurement(), 1'b0, '0);
         end
      end

      // One tick inside the capture band, on either side, enters balance mode.
      low_side        = $urandom_range(1, 0);
      m               = balance_measurement();
      m.pole_angle    = low_side ? 16'(pick(-32768, int'(ctrl_cfg.capture_band) - 1))
                                 : 16'(pick(ANGLE_2PI - int'(ctrl_cfg.capture_band) + 1,
                                            32767));
      send_measurement(m, 1'b0, '0);

      for (int p = 0; p < 6; p++) begin
         wait_for_drain();
         case (p)
            0, 4: apply_settings(SET_MILD);
            2: apply_settings(SET_HIGH);
            3: apply_settings(SET_LOW);
            default: apply_settings(SET_RANDOM);
         endcase
         set_idling(idling_e'(p % 4));
         if (p == 0) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < BALANCE_ITEMS; n++) begin
            if (p == 1 && n == BALANCE_ITEMS / 2) begin
               wait_for_drain();
            end
            send_measurement(balance_measurement(), 1'b0, '0);
         end
      end

      wait_for_drain();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_commands.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
